@@ rtl/mmsh_pkg.sv @@
// package: channel constants and shared types for the multi-modulus string hash
`default_nettype none
package mmsh_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_W        = 3;
  localparam int RES_W       = 57;
  localparam int BASE_W      = 17;
  localparam int RECIP_W     = 11;
  localparam int MIN_LEN_DEF = 16;
  localparam logic [63:0] PAD_MULT = 64'd1234567;

  typedef logic [RES_W-1:0] residue_t;

  function automatic residue_t chan_mod(input logic [CH_W-1:0] idx);
    residue_t m;
    case (idx)
      3'd0:    m = 57'd12345678901234567;
      3'd1:    m = 57'd36016490451032542;
      3'd2:    m = 57'd34810446721486217;
      3'd3:    m = 57'd93714874014602824;
      3'd4:    m = 57'd26487108525895710;
      3'd5:    m = 57'd52014709471650140;
      3'd6:    m = 57'd75916586147253187;
      3'd7:    m = 57'd83195614651364815;
      default: m = 57'd12345678901234567;
    endcase
    return m;
  endfunction

  // floor(2^64 / modulus), below 2^11 as every modulus exceeds 2^53
  function automatic logic [RECIP_W-1:0] chan_recip(input logic [CH_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    case (idx)
      3'd0:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd12345678901234567);
      3'd1:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd36016490451032542);
      3'd2:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd34810446721486217);
      3'd3:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd93714874014602824);
      3'd4:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd26487108525895710);
      3'd5:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd52014709471650140);
      3'd6:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd75916586147253187);
      3'd7:    r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd83195614651364815);
      default: r = RECIP_W'(64'hFFFF_FFFF_FFFF_FFFF / 64'd12345678901234567);
    endcase
    return r;
  endfunction

  function automatic logic [BASE_W-1:0] chan_base(input logic [CH_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      3'd0:    b = 17'd12345;
      3'd1:    b = 17'd83195;
      3'd2:    b = 17'd73914;
      3'd3:    b = 17'd83195;
      3'd4:    b = 17'd87314;
      3'd5:    b = 17'd56418;
      3'd6:    b = 17'd18591;
      3'd7:    b = 17'd34186;
      default: b = 17'd12345;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/multi_modulus_string_hash.sv @@
// multi-modulus string hash: sequencer, channel state and shared arithmetic units
// a data byte runs 8 channels x 4 operations on the shared multiplier and reducer;
// each pad byte runs 1 check, 5 pad multiplies and a channel pass
// the result is the XOR of all channel residues, folded in after the last channel pass
// one item at a time, in_ready only while idle
// reset: synchronous; residues zero, powers one, count and previous byte zero, no result held
`default_nettype none
module multi_modulus_string_hash #(
  parameter int MIN_LEN = mmsh_pkg::MIN_LEN_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         byte_valid,
  input  wire         last,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] hash_value
);
  import mmsh_pkg::*;

  localparam int CW = $clog2(MIN_LEN + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_R1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_R2   = 4'd4;
  localparam logic [3:0] S_PCHK = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_P3   = 4'd8;
  localparam logic [3:0] S_P4   = 4'd9;
  localparam logic [3:0] S_P5   = 4'd10;
  localparam logic [3:0] S_XOR  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]      state;
  logic            issued;
  logic [CH_W-1:0] ch;
  residue_t        residue [CHANNELS];
  residue_t        power   [CHANNELS];
  logic [CW-1:0]   byte_count;
  logic [7:0]      previous_byte;
  logic [7:0]      cur_byte;
  logic            pend_last;
  logic            pad_started;
  logic [CW-1:0]   len;
  logic [63:0]     sq;
  logic [63:0]     acc;

  logic            mul_start;
  logic            mul_done;
  logic [63:0]     mul_a;
  logic [63:0]     mul_b;
  logic [63:0]     mul_res;
  logic            mod_start;
  logic            mod_done;
  logic [63:0]     mod_x;
  residue_t        mod_res;

  logic            is_mul;
  logic            is_mod;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    is_mul = (state == S_M1) || (state == S_M2) || (state == S_P1) || (state == S_P2) ||
             (state == S_P3) || (state == S_P4) || (state == S_P5);
    is_mod = (state == S_R1) || (state == S_R2);
    mul_start = is_mul && !issued;
    mod_start = is_mod && !issued;
    mul_a = 64'd0;
    mul_b = 64'd0;
    case (state)
      S_M1: begin mul_a = {{56{cur_byte[7]}}, cur_byte}; mul_b = 64'(power[ch]); end
      S_M2: begin mul_a = 64'(power[ch]);              mul_b = 64'(chan_base(ch)); end
      S_P1: begin mul_a = 64'(byte_count);             mul_b = 64'(byte_count); end
      S_P2: begin mul_a = 64'(byte_count);             mul_b = 64'(byte_count) + 64'd1; end
      S_P3: begin mul_a = mul_res;                     mul_b = sq - 64'd1; end
      S_P4: begin mul_a = mul_res;                     mul_b = 64'(len) + 64'd1; end
      S_P5: begin mul_a = mul_res;                     mul_b = PAD_MULT; end
      default: begin mul_a = 64'd0; mul_b = 64'd0; end
    endcase
    // the sum wraps at 64 bits before the reduction
    if (state == S_R1) mod_x = 64'(residue[ch]) + mul_res;
    else               mod_x = mul_res;
  end

  mmsh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_res)
  );

  mmsh_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mod_x),
    .m     (chan_mod(ch)),
    .recip (chan_recip(ch)),
    .done  (mod_done),
    .rem   (mod_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      ch            <= '0;
      byte_count    <= '0;
      previous_byte <= 8'd0;
      pend_last     <= 1'b0;
      pad_started   <= 1'b0;
      out_valid     <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        residue[k] <= '0;
        power[k]   <= residue_t'(1);
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mul_start || mod_start) issued <= 1'b1;
      if (mul_done || mod_done)   issued <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_last <= last;
            cur_byte  <= data_byte;
            ch        <= '0;
            if (byte_valid)  state <= S_M1;
            else if (last)   state <= S_PCHK;
          end
        end
        S_M1: if (mul_done) state <= S_R1;
        S_R1: begin
          if (mod_done) begin
            residue[ch] <= mod_res;
            state       <= S_M2;
          end
        end
        S_M2: if (mul_done) state <= S_R2;
        S_R2: begin
          if (mod_done) begin
            power[ch] <= mod_res;
            if (ch == CH_W'(CHANNELS - 1)) begin
              if (byte_count < CW'(MIN_LEN)) byte_count <= byte_count + CW'(1);
              previous_byte <= cur_byte;
              state <= pend_last ? S_PCHK : S_IDLE;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= S_M1;
            end
          end
        end
        S_PCHK: begin
          if (!pad_started) begin
            len         <= byte_count;
            pad_started <= 1'b1;
          end
          ch  <= '0;
          acc <= 64'd0;
          if (byte_count >= CW'(MIN_LEN)) state <= S_XOR;
          else                            state <= S_P1;
        end
        S_P1: begin
          if (mul_done) begin
            sq    <= mul_res;
            state <= S_P2;
          end
        end
        S_P2: if (mul_done) state <= S_P3;
        S_P3: if (mul_done) state <= S_P4;
        S_P4: if (mul_done) state <= S_P5;
        S_P5: begin
          if (mul_done) begin
            // previous byte is still zero when the pad starts at position zero
            cur_byte <= mul_res[15:8] ^ previous_byte;
            ch       <= '0;
            state    <= S_M1;
          end
        end
        S_XOR: begin
          acc <= acc ^ 64'(residue[ch]);
          ch  <= ch + CH_W'(1);
          if (ch == CH_W'(CHANNELS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid     <= 1'b1;
            hash_value    <= acc;
            byte_count    <= '0;
            previous_byte <= 8'd0;
            pend_last     <= 1'b0;
            pad_started   <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
              residue[k] <= '0;
              power[k]   <= residue_t'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(MIN_LEN))
    else $error("byte count beyond minimum length");

  a_mod_bound: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (mod_res < chan_mod(ch)))
    else $error("reduced value not below modulus");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && mod_done))
    else $error("multiplier and reducer finished together");

  a_mod_in_reduce: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> ((state == S_R1) || (state == S_R2)))
    else $error("reduction finished outside a reduce step");

endmodule
`default_nettype wire

@@ rtl/mmsh_mul.sv @@
// iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle
`default_nettype none
module mmsh_mul (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] a,
  input  wire  [63:0] b,
  output logic        done,
  output logic [63:0] product
);
  import mmsh_pkg::*;

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] m_x;
  logic [31:0] m_y;
  logic [63:0] m_p;

  always_comb begin
    case (step)
      2'd0:    begin m_x = op_a[31:0];  m_y = op_b[31:0];  end
      2'd1:    begin m_x = op_a[31:0];  m_y = op_b[63:32]; end
      default: begin m_x = op_a[63:32]; m_y = op_b[31:0];  end
    endcase
    m_p = 64'(m_x) * 64'(m_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        op_a <= a;
        op_b <= b;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        case (step)
          2'd0:    product <= m_p;
          default: product <= product + {m_p[31:0], 32'd0};
        endcase
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/mmsh_mod.sv @@
// reducer: 64-bit value modulo a 57-bit constant by reciprocal estimate and correction
`default_nettype none
module mmsh_mod (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [63:0]                  x,
  input  mmsh_pkg::residue_t           m,
  input  wire  [mmsh_pkg::RECIP_W-1:0] recip,
  output logic                         done,
  output mmsh_pkg::residue_t           rem
);
  import mmsh_pkg::*;

  localparam int SHIFT = 43;
  localparam int XT_W  = 64 - SHIFT;
  localparam int QP_W  = XT_W + RECIP_W;
  localparam int QM_W  = RECIP_W + RES_W;
  localparam int PT_W  = RES_W + 2;

  logic [63:0]        val;
  residue_t           md;
  logic [RECIP_W-1:0] rc;
  logic [RECIP_W-1:0] q;
  logic [PT_W-1:0]    part;
  logic [1:0]         step;
  logic               busy;
  logic [QP_W-1:0]    q_prod;
  logic [QM_W-1:0]    qm;
  logic [PT_W-1:0]    diff;
  logic [PT_W-1:0]    m1;
  logic [PT_W-1:0]    m2;
  residue_t           fixed;

  always_comb begin
    // estimate never exceeds the true quotient and falls short by at most two
    q_prod = QP_W'(val[63:SHIFT]) * QP_W'(rc);
    qm     = QM_W'(q) * QM_W'(md);
    // remainder estimate is below three moduli, so the low bits suffice
    diff   = val[PT_W-1:0] - qm[PT_W-1:0];
    m1     = {2'b00, md};
    m2     = {1'b0, md, 1'b0};
    if (part >= m2)      fixed = residue_t'(part - m2);
    else if (part >= m1) fixed = residue_t'(part - m1);
    else                 fixed = part[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= x;
        md   <= m;
        rc   <= recip;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        case (step)
          2'd0:    q    <= q_prod[QP_W-1:XT_W];
          2'd1:    part <= diff;
          default: begin
            rem  <= fixed;
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
        step <= step + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_multi_modulus_string_hash.sv @@
// testbench for multi_modulus_string_hash: queue-fed driver, monitor and scoreboard
`default_nettype none
module tb_multi_modulus_string_hash;

  typedef struct {
    logic [7:0] data;
    logic       bv;
    logic       lst;
    bit         drain;   // wait for every hash to come back before offering
  } str_item_t;

  localparam logic [63:0] MODS [8] = '{
    64'd12345678901234567, 64'd36016490451032542, 64'd34810446721486217,
    64'd93714874014602824, 64'd26487108525895710, 64'd52014709471650140,
    64'd75916586147253187, 64'd83195614651364815};
  localparam logic [63:0] BASES [8] = '{
    64'd12345, 64'd83195, 64'd73914, 64'd83195, 64'd87314, 64'd56418, 64'd18591, 64'd34186};
  localparam int PAD_TO = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] hash_value;

  multi_modulus_string_hash u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  str_item_t   pending_items[$];
  logic [63:0] hashes_due[$];
  str_item_t   nxt;
  bit          in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cnt = 0;
  int          errors = 0;
  int          strings_done = 0;
  int          bytes_sent = 0;

  // running hash state
  logic [63:0] chan_res [8];
  logic [63:0] chan_pow [8];
  int unsigned byte_cnt;
  logic [7:0]  prev_b;

  function void clear_hash();
    for (int k = 0; k < 8; k++) begin
      chan_res[k] = 64'd0;
      chan_pow[k] = 64'd1;
    end
    byte_cnt = 0;
    prev_b = 8'd0;
  endfunction

  function void absorb_byte(input logic [7:0] b);
    logic [63:0] v;
    logic [63:0] t;
    v = {{56{b[7]}}, b};
    for (int k = 0; k < 8; k++) begin
      t = v * chan_pow[k];
      t = chan_res[k] + t;
      chan_res[k] = t % MODS[k];
      t = chan_pow[k] * BASES[k];
      chan_pow[k] = t % MODS[k];
    end
    if (byte_cnt < PAD_TO) byte_cnt++;
    prev_b = b;
  endfunction

  function void hash_item(input str_item_t it);
    logic [63:0] len, p, h;
    logic [7:0]  pb;
    if (it.bv) absorb_byte(it.data);
    if (it.lst) begin
      len = 64'(byte_cnt);
      for (logic [63:0] i = len; i < PAD_TO; i++) begin
        pb = (i > 0) ? prev_b : 8'd0;
        p = i * (i + 64'd1) * (i * i - 64'd1) * (len + 64'd1) * 64'd1234567;
        absorb_byte(p[15:8] ^ pb);
      end
      h = 64'd0;
      for (int k = 0; k < 8; k++) h ^= chan_res[k];
      hashes_due.push_back(h);
      clear_hash();
    end
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && !(pending_items[0].drain && hashes_due.size() > 0)
          && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= nxt.data;
        byte_valid <= nxt.bv;
        last       <= nxt.lst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with the long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  str_item_t seen;
  logic [63:0] want;
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen.data = data_byte;
        seen.bv   = byte_valid;
        seen.lst  = last;
        seen.drain = 1'b0;
        if (byte_valid) bytes_sent++;
        hash_item(seen);
      end
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          report_mismatch("unexpected hash_value", hash_value, 64'd0);
        end else begin
          want = hashes_due.pop_front();
          strings_done++;
          if (hash_value !== want) report_mismatch("hash_value", hash_value, want);
        end
      end
    end
  end

  task add_item(input logic [7:0] d, input logic bv, input logic l, input bit dr = 1'b0);
    str_item_t it;
    it.data = d; it.bv = bv; it.lst = l; it.drain = dr;
    pending_items.push_back(it);
  endtask

  // random string, mostly short, now and then at or past the padding length
  task add_string(input bit dr);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 6);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(7) == 0) add_item(8'($urandom), 1'b0, 1'b0);  // no-op transfer
      add_item(8'($urandom_range(255)), 1'b1, (j == n - 1) && $urandom_range(3) != 0,
               dr && j == 0);
    end
    if (n == 0 || !pending_items[$].lst) add_item(8'($urandom), 1'b0, 1'b1, dr && n == 0);
  endtask

  task run_phase(input int idle, input int stall, input int n_items);
    int start;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      if (pending_items.size() < 4) add_string($urandom_range(11) == 0);
      @(posedge clk);
    end
    while (pending_items.size() > 0) @(posedge clk);
  endtask

  initial begin
    clear_hash();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: empty string, zero byte, sign extremes, end-only close, ignored item
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h7f, 1'b1, 1'b0);
    add_item(8'h01, 1'b1, 1'b0);
    add_item(8'haa, 1'b0, 1'b1);
    add_item(8'h55, 1'b0, 1'b0);
    add_item(8'h55, 1'b1, 1'b1, 1'b1);
    for (int j = 0; j < 16; j++) add_item(8'(j * 17 + 1), 1'b1, j == 15);
    while (pending_items.size() > 0) @(posedge clk);
    hold_cnt = 20000;   // block fills and stalls its input meanwhile
    run_phase(0, 0, 90);
    run_phase(81, 0, 90);
    run_phase(0, 81, 90);
    run_phase(34, 34, 90);
    while (hashes_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d strings, %0d bytes, empty and long strings, all four idle phases",
             strings_done, bytes_sent);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d hashes outstanding", hashes_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
